>>> rtl/spsd_pkg.sv
`timescale 1ns / 1ps

package spsd_pkg;

   localparam int DEF_NUM_LINKS = 16;
   localparam int DEF_NUM_ROWS  = 8;

   localparam int ACTION_W  = 2;
   localparam int INDEX_W   = 4;
   localparam int ROW_W     = 16;
   localparam int DELAY_W   = 16;
   localparam int VEH_W     = 8;
   localparam int LIGHTS_W  = 32;
   localparam int PHASE_W   = 2;
   localparam int TIME_W    = 16;
   localparam int SUM_W     = 20;
   localparam int CNT_W     = 5;
   localparam int PROD_W    = VEH_W + TIME_W;
   localparam int QUOT_W    = 22;
   localparam int RECIP_SH  = 26;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Reciprocal of five, rounded up, scaled by two to the RECIP_SH.
   localparam logic [PROD_W-1:0] RECIP_5 = PROD_W'(((64'd1 << RECIP_SH) + 64'd4) / 64'd5);

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK     = 2'd0,
      ACT_LOAD_ROW = 2'd1,
      ACT_SET_LINK = 2'd2,
      ACT_START    = 2'd3
   } action_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_GREEN  = 2'd0,
      PH_YELLOW = 2'd1,
      PH_RED    = 2'd2
   } phase_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GREEN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GREEN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RT_MASK      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LIGHTS = 3'd5;

   localparam logic [TIME_W-1:0] RST_MIN_GREEN = 16'd50;
   localparam logic [TIME_W-1:0] RST_MAX_GREEN = 16'd600;
   localparam logic [TIME_W-1:0] RST_YELLOW    = 16'd30;
   localparam logic [TIME_W-1:0] RST_RED       = 16'd20;

   localparam logic [1:0] LIGHT_RED     = 2'd0;
   localparam logic [1:0] LIGHT_YELLOW  = 2'd1;
   localparam logic [1:0] LIGHT_GREEN   = 2'd2;
   localparam logic [1:0] LIGHT_PRIO    = 2'd3;

   typedef struct packed {
      logic exec;
      logic scan_clear;
      logic scan_step;
      logic row_end;
      logic mul;
      logic div;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic decide;
      logic link_last;
      logic row_last;
   } ctrl_status_type;

   function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
      at_least_one = (v == '0) ? TIME_W'(1) : v;
   endfunction

endpackage

>>> rtl/signal_phase_select_by_delay_core.sv
`timescale 1ns / 1ps
// Loads, start and ordinary ticks act while idle; a registered result appears the cycle after.
// A tick that ends a green interval runs the row scan, one link per cycle plus a row-end step
// per row, then the multiply, divide and finish steps.
// Throughput: one transaction per cycle while idle; busy is high from the row scan to finish.
// Synchronous reset restores register defaults, clears link statistics and stops the controller.
// Movement rows are undefined until loaded. Results are strobed for one cycle; no stall exists.

module signal_phase_select_by_delay_core
   import spsd_pkg::*;
#(
   parameter int NUM_LINKS = DEF_NUM_LINKS,
   parameter int NUM_ROWS  = DEF_NUM_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [ROW_W-1:0]      req_row_bits,
   input  logic [DELAY_W-1:0]    req_link_delay,
   input  logic [VEH_W-1:0]      req_link_vehicles,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_write_data,
   output logic                  rsp_strobe,
   output logic [LIGHTS_W-1:0]   rsp_lights,
   output logic [PHASE_W-1:0]    rsp_phase,
   output logic [TIME_W-1:0]     rsp_duration,
   output logic [INDEX_W-1:0]    rsp_chosen_row,
   output logic [VEH_W-1:0]      rsp_max_vehicles,
   output logic                  rsp_green_extended
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   spsd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   spsd_datapath #(
      .NUM_LINKS (NUM_LINKS),
      .NUM_ROWS  (NUM_ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_index          (req_index),
      .req_row_bits       (req_row_bits),
      .req_link_delay     (req_link_delay),
      .req_link_vehicles  (req_link_vehicles),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_lights         (rsp_lights),
      .rsp_phase          (rsp_phase),
      .rsp_duration       (rsp_duration),
      .rsp_chosen_row     (rsp_chosen_row),
      .rsp_max_vehicles   (rsp_max_vehicles),
      .rsp_green_extended (rsp_green_extended)
   );

endmodule

>>> rtl/spsd_ctrl.sv
`timescale 1ns / 1ps

module spsd_ctrl
   import spsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_ROWEND = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.decide) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  cmd.exec = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.link_last) begin
               state_in = ST_ROWEND;
            end
         end
         ST_ROWEND: begin
            cmd.row_end = 1'b1;
            state_in    = status.row_last ? ST_MUL : ST_SCAN;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/spsd_datapath.sv
`timescale 1ns / 1ps

module spsd_datapath
   import spsd_pkg::*;
#(
   parameter int NUM_LINKS = DEF_NUM_LINKS,
   parameter int NUM_ROWS  = DEF_NUM_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [ROW_W-1:0]      req_row_bits,
   input  logic [DELAY_W-1:0]    req_link_delay,
   input  logic [VEH_W-1:0]      req_link_vehicles,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_write_data,
   output logic                  rsp_strobe,
   output logic [LIGHTS_W-1:0]   rsp_lights,
   output logic [PHASE_W-1:0]    rsp_phase,
   output logic [TIME_W-1:0]     rsp_duration,
   output logic [INDEX_W-1:0]    rsp_chosen_row,
   output logic [VEH_W-1:0]      rsp_max_vehicles,
   output logic                  rsp_green_extended
);

   localparam int LINK_IW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
   localparam int ROW_IW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam logic [LIGHTS_W-1:0] LIGHT_MASK =
      LIGHTS_W'((64'd1 << (2 * NUM_LINKS)) - 64'd1);
   localparam int NUM_SLOTS = LIGHTS_W / 2;

   logic [TIME_W-1:0]   min_green_ff, max_green_ff, yellow_ff, red_ff;
   logic [ROW_W-1:0]    rt_mask_ff;
   logic [LIGHTS_W-1:0] start_lights_ff;

   logic [ROW_W-1:0]    row_table_ff [NUM_ROWS];
   logic [DELAY_W-1:0]  delay_ff     [NUM_LINKS];
   logic [VEH_W-1:0]    veh_ff       [NUM_LINKS];

   logic [LIGHTS_W-1:0] cur_lights_ff, cur_lights_in;
   logic [LIGHTS_W-1:0] pend_lights_ff, pend_lights_in;
   logic [TIME_W-1:0]   pend_time_ff, pend_time_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [TIME_W-1:0]   ticks_ff, ticks_in;
   logic                running_ff, running_in;

   logic [LINK_IW-1:0]  link_cnt_ff, link_cnt_in;
   logic [ROW_IW-1:0]   row_cnt_ff, row_cnt_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [VEH_W-1:0]    mv_ff, mv_in;
   logic [ROW_IW-1:0]   best_row_ff, best_row_in;
   logic [SUM_W-1:0]    best_sum_ff, best_sum_in;
   logic [CNT_W-1:0]    best_cnt_ff, best_cnt_in;
   logic [VEH_W-1:0]    best_veh_ff, best_veh_in;
   logic [NUM_LINKS-1:0] best_bits_ff, best_bits_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [LIGHTS_W-1:0] rsp_lights_ff, rsp_lights_in;
   logic [PHASE_W-1:0]  rsp_phase_ff, rsp_phase_in;
   logic [TIME_W-1:0]   rsp_duration_ff, rsp_duration_in;
   logic [INDEX_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [VEH_W-1:0]    rsp_veh_ff, rsp_veh_in;
   logic                rsp_ext_ff, rsp_ext_in;

   logic [NUM_LINKS-1:0] row_word;
   logic [NUM_LINKS-1:0] rt_links;
   logic                 link_on, link_counts;
   logic                 row_wins;
   logic [2*PROD_W-1:0]  recip_full;
   logic [QUOT_W-1:0]    gt_low;
   logic [TIME_W-1:0]    green_time;
   logic [LIGHTS_W-1:0]  next_lights, shown_lights, cleared_lights;
   logic                 need_yellow;
   logic                 row_ok, link_ok;

   assign row_word    = row_table_ff[row_cnt_ff][NUM_LINKS-1:0];
   assign rt_links    = rt_mask_ff[NUM_LINKS-1:0];
   assign link_on     = row_word[link_cnt_ff];
   assign link_counts = link_on && !rt_links[link_cnt_ff];

   assign row_wins = (row_cnt_ff == '0) || (sum_ff > best_sum_ff) ||
                     ((sum_ff == best_sum_ff) && (cnt_ff > best_cnt_ff));

   assign recip_full = (2*PROD_W)'(prod_ff) * (2*PROD_W)'(RECIP_5);
   assign quot_in    = recip_full[RECIP_SH +: QUOT_W];
   assign prod_in    = PROD_W'(best_veh_ff) * PROD_W'(min_green_ff);

   assign gt_low     = (quot_ff < QUOT_W'(min_green_ff)) ? QUOT_W'(min_green_ff) : quot_ff;
   assign green_time = (gt_low > QUOT_W'(max_green_ff)) ? max_green_ff : gt_low[TIME_W-1:0];

   assign row_ok  = ({1'b0, req_index} < (INDEX_W+1)'(NUM_ROWS));
   assign link_ok = ({1'b0, req_index} < (INDEX_W+1)'(NUM_LINKS));

   assign status.decide    = (req_action == ACT_TICK) && running_ff &&
                             (ticks_ff < TIME_W'(2)) && (phase_ff == PH_GREEN);
   assign status.link_last = (link_cnt_ff == LINK_IW'(NUM_LINKS - 1));
   assign status.row_last  = (row_cnt_ff == ROW_IW'(NUM_ROWS - 1));

   always_comb begin
      next_lights    = '0;
      shown_lights   = cur_lights_ff;
      need_yellow    = 1'b0;
      cleared_lights = cur_lights_ff;
      for (int l = 0; l < NUM_LINKS; l++) begin
         logic [1:0] code;
         code = !best_bits_ff[l] ? LIGHT_RED : (rt_links[l] ? LIGHT_GREEN : LIGHT_PRIO);
         next_lights[2*l +: 2] = code;
         if ((cur_lights_ff[2*l +: 2] >= LIGHT_GREEN) && (code == LIGHT_RED)) begin
            shown_lights[2*l +: 2] = LIGHT_YELLOW;
            need_yellow            = 1'b1;
         end
      end
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (cur_lights_ff[2*s +: 2] == LIGHT_YELLOW) begin
            cleared_lights[2*s +: 2] = LIGHT_RED;
         end
      end
   end

   always_comb begin
      cur_lights_in   = cur_lights_ff;
      pend_lights_in  = pend_lights_ff;
      pend_time_in    = pend_time_ff;
      phase_in        = phase_ff;
      ticks_in        = ticks_ff;
      running_in      = running_ff;
      link_cnt_in     = link_cnt_ff;
      row_cnt_in      = row_cnt_ff;
      sum_in          = sum_ff;
      cnt_in          = cnt_ff;
      mv_in           = mv_ff;
      best_row_in     = best_row_ff;
      best_sum_in     = best_sum_ff;
      best_cnt_in     = best_cnt_ff;
      best_veh_in     = best_veh_ff;
      best_bits_in    = best_bits_ff;
      rsp_strobe_in   = 1'b0;
      rsp_lights_in   = rsp_lights_ff;
      rsp_phase_in    = rsp_phase_ff;
      rsp_duration_in = rsp_duration_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_veh_in      = rsp_veh_ff;
      rsp_ext_in      = rsp_ext_ff;

      if (cmd.exec) begin
         unique case (req_action)
            ACT_START: begin
               cur_lights_in   = start_lights_ff & LIGHT_MASK;
               phase_in        = PH_GREEN;
               ticks_in        = at_least_one(min_green_ff);
               running_in      = 1'b1;
               rsp_strobe_in   = 1'b1;
               rsp_lights_in   = start_lights_ff & LIGHT_MASK;
               rsp_phase_in    = PH_GREEN;
               rsp_duration_in = at_least_one(min_green_ff);
               rsp_row_in      = '0;
               rsp_veh_in      = '0;
               rsp_ext_in      = 1'b0;
            end
            ACT_TICK: begin
               if (running_ff) begin
                  priority if (ticks_ff > TIME_W'(1)) begin
                     ticks_in = ticks_ff - TIME_W'(1);
                  end else if (phase_ff == PH_YELLOW) begin
                     cur_lights_in   = cleared_lights;
                     phase_in        = PH_RED;
                     ticks_in        = at_least_one(red_ff);
                     rsp_strobe_in   = 1'b1;
                     rsp_lights_in   = cleared_lights;
                     rsp_phase_in    = PH_RED;
                     rsp_duration_in = at_least_one(red_ff);
                     rsp_row_in      = '0;
                     rsp_veh_in      = '0;
                     rsp_ext_in      = 1'b0;
                  end else if (phase_ff == PH_RED) begin
                     cur_lights_in   = pend_lights_ff & LIGHT_MASK;
                     phase_in        = PH_GREEN;
                     ticks_in        = at_least_one(pend_time_ff);
                     rsp_strobe_in   = 1'b1;
                     rsp_lights_in   = pend_lights_ff & LIGHT_MASK;
                     rsp_phase_in    = PH_GREEN;
                     rsp_duration_in = at_least_one(pend_time_ff);
                     rsp_row_in      = '0;
                     rsp_veh_in      = '0;
                     rsp_ext_in      = 1'b0;
                  end else begin
                     ticks_in = ticks_ff;
                  end
               end
            end
            default: begin
               ticks_in = ticks_ff;
            end
         endcase
      end

      if (cmd.scan_clear) begin
         link_cnt_in = '0;
         row_cnt_in  = '0;
         sum_in      = '0;
         cnt_in      = '0;
         mv_in       = '0;
      end

      if (cmd.scan_step) begin
         link_cnt_in = status.link_last ? '0 : link_cnt_ff + LINK_IW'(1);
         if (link_on) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         if (link_counts) begin
            sum_in = sum_ff + SUM_W'(delay_ff[link_cnt_ff]);
            if (veh_ff[link_cnt_ff] > mv_ff) begin
               mv_in = veh_ff[link_cnt_ff];
            end
         end
      end

      if (cmd.row_end) begin
         if (row_wins) begin
            best_row_in  = row_cnt_ff;
            best_sum_in  = sum_ff;
            best_cnt_in  = cnt_ff;
            best_veh_in  = mv_ff;
            best_bits_in = row_word;
         end
         row_cnt_in = row_cnt_ff + ROW_IW'(1);
         sum_in     = '0;
         cnt_in     = '0;
         mv_in      = '0;
      end

      if (cmd.finish) begin
         pend_lights_in  = next_lights;
         pend_time_in    = green_time;
         rsp_strobe_in   = 1'b1;
         rsp_row_in      = INDEX_W'(best_row_ff);
         rsp_veh_in      = best_veh_ff;
         if (need_yellow) begin
            cur_lights_in   = shown_lights;
            phase_in        = PH_YELLOW;
            ticks_in        = at_least_one(yellow_ff);
            rsp_lights_in   = shown_lights;
            rsp_phase_in    = PH_YELLOW;
            rsp_duration_in = at_least_one(yellow_ff);
            rsp_ext_in      = 1'b0;
         end else begin
            ticks_in        = at_least_one(green_time);
            rsp_lights_in   = cur_lights_ff;
            rsp_phase_in    = phase_ff;
            rsp_duration_in = at_least_one(green_time);
            rsp_ext_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_green_ff    <= RST_MIN_GREEN;
         max_green_ff    <= RST_MAX_GREEN;
         yellow_ff       <= RST_YELLOW;
         red_ff          <= RST_RED;
         rt_mask_ff      <= '0;
         start_lights_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_GREEN:    min_green_ff    <= csr_write_data[TIME_W-1:0];
            CSR_MAX_GREEN:    max_green_ff    <= csr_write_data[TIME_W-1:0];
            CSR_YELLOW:       yellow_ff       <= csr_write_data[TIME_W-1:0];
            CSR_RED:          red_ff          <= csr_write_data[TIME_W-1:0];
            CSR_RT_MASK:      rt_mask_ff      <= csr_write_data[ROW_W-1:0];
            CSR_START_LIGHTS: start_lights_ff <= csr_write_data[LIGHTS_W-1:0];
            default: begin
               min_green_ff <= min_green_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && (req_action == ACT_LOAD_ROW) && row_ok) begin
         row_table_ff[req_index[ROW_IW-1:0]] <= req_row_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LINKS; l++) begin
            delay_ff[l] <= '0;
            veh_ff[l]   <= '0;
         end
      end else if (cmd.exec && (req_action == ACT_SET_LINK) && link_ok) begin
         delay_ff[req_index[LINK_IW-1:0]] <= req_link_delay;
         veh_ff[req_index[LINK_IW-1:0]]   <= req_link_vehicles;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_lights_ff  <= '0;
         pend_lights_ff <= '0;
         pend_time_ff   <= '0;
         phase_ff       <= PH_GREEN;
         ticks_ff       <= '0;
         running_ff     <= 1'b0;
         link_cnt_ff    <= '0;
         row_cnt_ff     <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         cur_lights_ff  <= cur_lights_in;
         pend_lights_ff <= pend_lights_in;
         pend_time_ff   <= pend_time_in;
         phase_ff       <= phase_in;
         ticks_ff       <= ticks_in;
         running_ff     <= running_in;
         link_cnt_ff    <= link_cnt_in;
         row_cnt_ff     <= row_cnt_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff          <= sum_in;
      cnt_ff          <= cnt_in;
      mv_ff           <= mv_in;
      best_row_ff     <= best_row_in;
      best_sum_ff     <= best_sum_in;
      best_cnt_ff     <= best_cnt_in;
      best_veh_ff     <= best_veh_in;
      best_bits_ff    <= best_bits_in;
      prod_ff         <= cmd.mul ? prod_in : prod_ff;
      quot_ff         <= cmd.div ? quot_in : quot_ff;
      rsp_lights_ff   <= rsp_lights_in;
      rsp_phase_ff    <= rsp_phase_in;
      rsp_duration_ff <= rsp_duration_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_veh_ff      <= rsp_veh_in;
      rsp_ext_ff      <= rsp_ext_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_lights         = rsp_lights_ff;
   assign rsp_phase          = rsp_phase_ff;
   assign rsp_duration       = rsp_duration_ff;
   assign rsp_chosen_row     = rsp_row_ff;
   assign rsp_max_vehicles   = rsp_veh_ff;
   assign rsp_green_extended = rsp_ext_ff;

endmodule
